// ----- rtl/core/tdsac_pkg.sv -----
package tdsac_pkg;

  // Data path widths
  localparam int ADC_BITS         = 12;
  localparam int MAX_SAMPLES_LOG2 = 4;
  localparam int SUM_W            = ADC_BITS + MAX_SAMPLES_LOG2;
  localparam int CNT_W            = MAX_SAMPLES_LOG2 + 1;
  localparam int LG_W             = 3;
  localparam int WIN_W            = 12;
  localparam int CMP_W            = (ADC_BITS > WIN_W) ? ADC_BITS : WIN_W;
  localparam int SETTLE_W         = 16;
  localparam int TDS_W            = 15;
  localparam int RANGE_W          = 2;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 16;

  // Q16 calibration arithmetic
  localparam int Q_FRAC  = 16;
  localparam int A_W     = 11;
  localparam int B_W     = 18;
  localparam int C_W     = 26;
  localparam int VV_W    = 2 * ADC_BITS;
  localparam int BV_W    = B_W + ADC_BITS + 1;
  localparam int AVV_W   = A_W + VV_W + 1;
  localparam int CB_W    = ((BV_W > C_W) ? BV_W : C_W) + 1;
  localparam int ACC_W   = ((AVV_W > CB_W) ? AVV_W : CB_W) + 1;
  localparam int PPM_W   = ACC_W - Q_FRAC;
  localparam int TDS_MAX = 32767;

  // Register reset values
  localparam logic [SETTLE_W-1:0] SETTLE_RESET   = 16'd1000;
  localparam logic [LG_W-1:0]     LOG2_RESET     = 3'd3;
  localparam logic [WIN_W-1:0]    WIN_LOW_RESET  = 12'd100;
  localparam logic [WIN_W-1:0]    WIN_HIGH_RESET = 12'd1500;

  // Input commands
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // End ranges
  localparam logic [RANGE_W-1:0] RANGE_LOWEST  = 2'd0;
  localparam logic [RANGE_W-1:0] RANGE_HIGHEST = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIPE_SIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_MS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_LOG2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH  = 3'd4;

  typedef enum logic [1:0] {
    ST_UPDATED,
    ST_STEP_DOWN,
    ST_STEP_UP,
    ST_END_RANGE
  } tdsac_status_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_MUL1,
    BS_MUL2,
    BS_FIN
  } tdsac_bstate_t;

  typedef struct packed {
    logic                pipe_size;
    logic [SETTLE_W-1:0] settle_ms;
    logic [LG_W-1:0]     samples_log2;
    logic [WIN_W-1:0]    window_low;
    logic [WIN_W-1:0]    window_high;
  } tdsac_cfg_t;

  // Back end to front end: reading taken, and whether settling restarts
  typedef struct packed {
    logic done;
    logic reload;
  } tdsac_fb_t;

  typedef struct packed {
    logic signed [A_W-1:0] a;
    logic signed [B_W-1:0] b;
    logic signed [C_W-1:0] c;
  } tdsac_coef_t;

  // Calibration curves in Q16: a*v*v + b*v + c
  function automatic tdsac_coef_t curve_coef(input logic pipe, input logic [RANGE_W-1:0] rng);
    tdsac_coef_t k;
    case ({pipe, rng})
      3'd0:    k = '{a: 11'sd518, b: 18'sd92674,  c: 26'sd23459135};
      3'd1:    k = '{a: 11'sd0,   b: 18'sd34026,  c: -26'sd1217967};
      3'd2:    k = '{a: 11'sd0,   b: 18'sd3163,   c: -26'sd84227};
      3'd3:    k = '{a: 11'sd0,   b: 18'sd358,    c: -26'sd21725};
      3'd4:    k = '{a: 11'sd398, b: -18'sd57403, c: 26'sd27533404};
      3'd5:    k = '{a: 11'sd0,   b: 18'sd19792,  c: -26'sd299565};
      3'd6:    k = '{a: 11'sd0,   b: 18'sd1766,   c: -26'sd104006};
      default: k = '{a: 11'sd0,   b: 18'sd175,    c: -26'sd63459};
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/core/tdsac_queue.sv -----
module tdsac_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  logic [tdsac_pkg::ADC_BITS-1:0]   push_data,
  input  logic                             pop,
  output logic [tdsac_pkg::ADC_BITS-1:0]   pop_data,
  output logic                             empty,
  output logic                             full
);

  // Two-entry queue of averages between front and back end
  logic [tdsac_pkg::ADC_BITS-1:0] mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign empty    = (count_r == 2'd0);
  assign full     = (count_r == 2'd2);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/core/tdsac_front.sv -----
module tdsac_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_command,
  input  logic [tdsac_pkg::ADC_BITS-1:0]   in_sample_value,
  input  tdsac_pkg::tdsac_cfg_t            cfg,
  input  logic                             clr_acc,
  input  tdsac_pkg::tdsac_fb_t             fb,
  input  logic                             q_full,
  output logic                             q_push,
  output logic [tdsac_pkg::ADC_BITS-1:0]   q_data
);

  logic [tdsac_pkg::SETTLE_W-1:0] settle_left_r, settle_left_nxt;
  logic [tdsac_pkg::SUM_W-1:0]    sum_r, sum_nxt, sum_add;
  logic [tdsac_pkg::CNT_W-1:0]    taken_r, taken_nxt, taken_add, target;
  logic                           pending_r, pending_nxt;
  logic [tdsac_pkg::LG_W-1:0]     eff_log2;
  logic                           accept;

  // Input is held off while a finished reading waits for its range decision or the queue is full
  assign in_ready = !pending_r && !q_full;
  assign accept   = in_valid && in_ready;

  // Effective averaging depth
  always_comb begin
    if (cfg.samples_log2 > tdsac_pkg::LG_W'(tdsac_pkg::MAX_SAMPLES_LOG2)) begin
      eff_log2 = tdsac_pkg::LG_W'(tdsac_pkg::MAX_SAMPLES_LOG2);
    end else begin
      eff_log2 = cfg.samples_log2;
    end
    target    = tdsac_pkg::CNT_W'(1) << eff_log2;
    sum_add   = sum_r + tdsac_pkg::SUM_W'(in_sample_value);
    taken_add = taken_r + tdsac_pkg::CNT_W'(1);
  end

  // Settle count, accumulation and reading hand-off
  always_comb begin
    settle_left_nxt = settle_left_r;
    sum_nxt         = sum_r;
    taken_nxt       = taken_r;
    pending_nxt     = pending_r;
    q_push          = 1'b0;
    q_data          = tdsac_pkg::ADC_BITS'(sum_add >> eff_log2);
    if (accept) begin
      if (in_command == tdsac_pkg::CMD_TICK) begin
        if (settle_left_r != '0) begin
          settle_left_nxt = settle_left_r - tdsac_pkg::SETTLE_W'(1);
        end
      end else if (settle_left_r == '0) begin
        if (taken_add == target) begin
          q_push      = 1'b1;
          sum_nxt     = '0;
          taken_nxt   = '0;
          pending_nxt = 1'b1;
        end else begin
          sum_nxt   = sum_add;
          taken_nxt = taken_add;
        end
      end
    end
    if (clr_acc) begin
      sum_nxt   = '0;
      taken_nxt = '0;
    end
    if (fb.done) begin
      pending_nxt = 1'b0;
      if (fb.reload) begin
        settle_left_nxt = cfg.settle_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_left_r <= tdsac_pkg::SETTLE_RESET;
      sum_r         <= '0;
      taken_r       <= '0;
      pending_r     <= 1'b0;
    end else begin
      settle_left_r <= settle_left_nxt;
      sum_r         <= sum_nxt;
      taken_r       <= taken_nxt;
      pending_r     <= pending_nxt;
    end
  end

  // A reading is only produced once settled
  a_push_settled: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (settle_left_r == '0))
    else $error("reading produced while settling");

  // A range switch always answers a reading that is pending
  a_reload_pending: assert property (@(posedge clk) disable iff (!rst_n)
    fb.reload |-> (pending_r && fb.done))
    else $error("settle reload without a pending reading");

endmodule

// ----- rtl/core/tdsac_back.sv -----
module tdsac_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tdsac_pkg::tdsac_cfg_t            cfg,
  input  logic                             q_empty,
  input  logic [tdsac_pkg::ADC_BITS-1:0]   q_data,
  output logic                             q_pop,
  output tdsac_pkg::tdsac_fb_t             fb,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tdsac_pkg::TDS_W-1:0]      out_tds_ppm,
  output logic [tdsac_pkg::RANGE_W-1:0]    out_range_select,
  output logic [1:0]                       out_status
);

  tdsac_pkg::tdsac_bstate_t state_r, state_nxt;

  logic [tdsac_pkg::RANGE_W-1:0]      range_r, range_nxt;
  logic [tdsac_pkg::TDS_W-1:0]        last_tds_r;
  tdsac_pkg::tdsac_status_t           st_dec, status_r;
  logic [tdsac_pkg::ADC_BITS-1:0]     v_r;
  tdsac_pkg::tdsac_coef_t             coef_r;
  logic [tdsac_pkg::VV_W-1:0]         vv_r;
  logic signed [tdsac_pkg::BV_W-1:0]  bv_r;
  logic signed [tdsac_pkg::AVV_W-1:0] avv_r;
  logic signed [tdsac_pkg::CB_W-1:0]  cb_r;
  logic signed [tdsac_pkg::ACC_W-1:0] acc;
  logic [tdsac_pkg::PPM_W-1:0]        ppm_raw;
  logic [tdsac_pkg::TDS_W-1:0]        ppm;
  logic [tdsac_pkg::CMP_W-1:0]        avg_c, lo_c, hi_c;
  logic                               load;
  logic                               out_valid_r;
  logic [tdsac_pkg::TDS_W-1:0]        out_tds_r;
  logic [tdsac_pkg::RANGE_W-1:0]      out_range_r;
  tdsac_pkg::tdsac_status_t           out_status_r;

  // Window test and range decision on the queue head
  always_comb begin
    avg_c     = tdsac_pkg::CMP_W'(q_data);
    lo_c      = tdsac_pkg::CMP_W'(cfg.window_low);
    hi_c      = tdsac_pkg::CMP_W'(cfg.window_high);
    range_nxt = range_r;
    if (avg_c >= lo_c && avg_c <= hi_c) begin
      st_dec = tdsac_pkg::ST_UPDATED;
    end else if (avg_c > hi_c && range_r != tdsac_pkg::RANGE_LOWEST) begin
      st_dec    = tdsac_pkg::ST_STEP_DOWN;
      range_nxt = range_r - tdsac_pkg::RANGE_W'(1);
    end else if (avg_c < lo_c && range_r != tdsac_pkg::RANGE_HIGHEST) begin
      st_dec    = tdsac_pkg::ST_STEP_UP;
      range_nxt = range_r + tdsac_pkg::RANGE_W'(1);
    end else begin
      st_dec = tdsac_pkg::ST_END_RANGE;
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tdsac_pkg::BS_IDLE: begin
        if (!q_empty) begin
          state_nxt = tdsac_pkg::BS_MUL1;
        end
      end
      tdsac_pkg::BS_MUL1: state_nxt = tdsac_pkg::BS_MUL2;
      tdsac_pkg::BS_MUL2: state_nxt = tdsac_pkg::BS_FIN;
      tdsac_pkg::BS_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = tdsac_pkg::BS_IDLE;
        end
      end
      default: state_nxt = tdsac_pkg::BS_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop     = (state_r == tdsac_pkg::BS_IDLE) && !q_empty;
    load      = (state_r == tdsac_pkg::BS_FIN) && (!out_valid_r || out_ready);
    fb.done   = q_pop;
    fb.reload = q_pop && (st_dec == tdsac_pkg::ST_STEP_DOWN ||
                          st_dec == tdsac_pkg::ST_STEP_UP);
  end

  // Final sum, truncation and saturation
  always_comb begin
    acc     = tdsac_pkg::ACC_W'(avv_r) + tdsac_pkg::ACC_W'(cb_r);
    ppm_raw = acc[tdsac_pkg::ACC_W-1:tdsac_pkg::Q_FRAC];
    if (acc <= 0) begin
      ppm = '0;
    end else if (ppm_raw > tdsac_pkg::PPM_W'(tdsac_pkg::TDS_MAX)) begin
      ppm = tdsac_pkg::TDS_W'(tdsac_pkg::TDS_MAX);
    end else begin
      ppm = ppm_raw[tdsac_pkg::TDS_W-1:0];
    end
  end

  // Conversion data path: capture on pop, square and linear term, then quadratic term and constant, then output load
  always_ff @(posedge clk) begin
    if (q_pop) begin
      v_r      <= q_data;
      coef_r   <= tdsac_pkg::curve_coef(cfg.pipe_size, range_r);
      status_r <= st_dec;
    end
    if (state_r == tdsac_pkg::BS_MUL1) begin
      vv_r <= v_r * v_r;
      bv_r <= $signed(coef_r.b) * $signed({1'b0, v_r});
    end
    if (state_r == tdsac_pkg::BS_MUL2) begin
      avv_r <= $signed(coef_r.a) * $signed({1'b0, vv_r});
      cb_r  <= tdsac_pkg::CB_W'(bv_r) + tdsac_pkg::CB_W'($signed(coef_r.c));
    end
    if (load) begin
      out_tds_r    <= (status_r == tdsac_pkg::ST_UPDATED) ? ppm : last_tds_r;
      out_range_r  <= range_r;
      out_status_r <= status_r;
    end
  end

  // Control and meter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tdsac_pkg::BS_IDLE;
      range_r     <= tdsac_pkg::RANGE_HIGHEST;
      last_tds_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        range_r <= range_nxt;
      end
      if (load && status_r == tdsac_pkg::ST_UPDATED) begin
        last_tds_r <= ppm;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tds_ppm      = out_tds_r;
  assign out_range_select = out_range_r;
  assign out_status       = out_status_r;

  // Range moves only when a reading is taken from the queue
  a_range_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !q_pop |=> $stable(range_r))
    else $error("range changed without a reading");

  // A step down lowers the range by exactly one
  a_step_down: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && st_dec == tdsac_pkg::ST_STEP_DOWN) |=>
      (range_r == tdsac_pkg::RANGE_W'($past(range_r) - tdsac_pkg::RANGE_W'(1))))
    else $error("step down did not lower the range by one");

  // The shown value always matches the latest value from an in-window reading
  a_tds_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_tds_r == last_tds_r))
    else $error("output ppm differs from latest value");

endmodule

// ----- rtl/core/tds_autorange_calibrator_unit.sv -----
// Auto-ranging TDS meter with calibration.
// Input channel (in_valid/in_ready): in_command 0 is a one millisecond tick,
// 1 carries an ADC sample in in_sample_value. Ticks count down the settle
// time; samples taken while settling are dropped. After settling, groups of
// 2^samples_log2 samples (samples_log2 capped at 4) are averaged into one reading.
// Result channel (out_valid/out_ready): one transaction per reading with the
// ppm value, the range now selected and a status code.
// Configuration: cfg_we writes cfg_data to register cfg_index;
// index 0 pipe size, 1 settle ms, 2 samples log2, 3 window low, 4 window high.
// Timing: ticks and samples that do not finish a reading are taken one per
// cycle while in_ready is high. A reading passes through the queue, the pop
// with its range decision, two multiply stages, sum and saturate and the
// output register; the back end takes one reading at a time. in_ready drops
// after each reading until the back end pops it and makes its range decision.
// Reset: range 3, settle count 1000 ticks, accumulator and last ppm cleared.
// A stalled receiver holds the result in the output register; one further
// reading can wait in the queue, after which in_ready stays low.
module tds_autorange_calibrator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_command,
  input  logic [tdsac_pkg::ADC_BITS-1:0]     in_sample_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tdsac_pkg::TDS_W-1:0]        out_tds_ppm,
  output logic [tdsac_pkg::RANGE_W-1:0]      out_range_select,
  output logic [1:0]                         out_status,
  input  logic                               cfg_we,
  input  logic [tdsac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tdsac_pkg::CFG_DATA_W-1:0]   cfg_data
);

  tdsac_pkg::tdsac_cfg_t cfg_r, cfg_nxt;
  tdsac_pkg::tdsac_fb_t  fb;
  logic                  clr_acc;
  logic                  q_push, q_pop, q_empty, q_full;
  logic [tdsac_pkg::ADC_BITS-1:0] q_wdata, q_rdata;

  // Configuration register decode
  always_comb begin
    cfg_nxt = cfg_r;
    clr_acc = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        tdsac_pkg::CFG_PIPE_SIZE:    cfg_nxt.pipe_size = cfg_data[0];
        tdsac_pkg::CFG_SETTLE_MS:    cfg_nxt.settle_ms = cfg_data[tdsac_pkg::SETTLE_W-1:0];
        tdsac_pkg::CFG_SAMPLES_LOG2: begin
          cfg_nxt.samples_log2 = cfg_data[tdsac_pkg::LG_W-1:0];
          clr_acc              = 1'b1;
        end
        tdsac_pkg::CFG_WINDOW_LOW:   cfg_nxt.window_low  = cfg_data[tdsac_pkg::WIN_W-1:0];
        tdsac_pkg::CFG_WINDOW_HIGH:  cfg_nxt.window_high = cfg_data[tdsac_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pipe_size    <= 1'b0;
      cfg_r.settle_ms    <= tdsac_pkg::SETTLE_RESET;
      cfg_r.samples_log2 <= tdsac_pkg::LOG2_RESET;
      cfg_r.window_low   <= tdsac_pkg::WIN_LOW_RESET;
      cfg_r.window_high  <= tdsac_pkg::WIN_HIGH_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tdsac_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_sample_value (in_sample_value),
    .cfg             (cfg_r),
    .clr_acc         (clr_acc),
    .fb              (fb),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_wdata)
  );

  tdsac_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty),
    .full      (q_full)
  );

  tdsac_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .q_data           (q_rdata),
    .q_pop            (q_pop),
    .fb               (fb),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tds_ppm      (out_tds_ppm),
    .out_range_select (out_range_select),
    .out_status       (out_status)
  );

endmodule
